// ===== rtl/nbpa_pkg.sv =====
// ----------------------------------------------------------------------------
// nbpa_pkg
// shared widths, register indexes and interface types of the pair
// acceleration accumulator
// ----------------------------------------------------------------------------
package nbpa_pkg;

    // position width, Q16.16 at the default
    localparam int POS_WIDTH  = 32;

    localparam int CFG_W      = 32;
    localparam int MASS_W     = 32;
    localparam int DIFF_W     = POS_WIDTH + 1;
    localparam int MAG_W      = POS_WIDTH + 1;
    localparam int RAD_W      = 2 * MAG_W;
    localparam int ROOT_W     = MAG_W;
    localparam int D2_W       = 2 * ROOT_W;
    localparam int D3_W       = 3 * ROOT_W;
    localparam int SOFT_SHIFT = 32;
    localparam int SOFT_W     = CFG_W + SOFT_SHIFT;
    localparam int DEN_W      = ((D3_W > SOFT_W) ? D3_W : SOFT_W) + 1;
    localparam int GM_W       = 2 * CFG_W;
    localparam int GM_HALF    = CFG_W;
    localparam int NX_W       = GM_W + MAG_W;
    localparam int FRAC_SHIFT = 24;
    localparam int NUM_W      = NX_W + FRAC_SHIFT;
    localparam int Q_W        = 48;
    localparam int HI_W       = NUM_W - Q_W;
    localparam int REM_W      = ((DEN_W + 1) > HI_W) ? (DEN_W + 1) : HI_W;
    localparam int TERM_W     = 47;
    localparam int ACC_W      = 48;

    localparam int ROOT_CNT_W = $clog2(ROOT_W + 1);
    localparam int DIV_CNT_W  = $clog2(Q_W + 1);

    localparam int S_FIELDS_W = 4 * POS_WIDTH + MASS_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int S_TUSER_W  = 2;
    localparam int M_TDATA_W  = 2 * ACC_W;
    localparam int M_TUSER_W  = 1;

    // configuration register indexes
    localparam int REG_IDX_W = 1;
    localparam logic [REG_IDX_W-1:0] REG_GRAV_CONST = 1'b0;
    localparam logic [REG_IDX_W-1:0] REG_SOFTENING  = 1'b1;

    localparam logic [CFG_W-1:0] GRAV_RESET = 32'd65536;
    localparam logic [CFG_W-1:0] SOFT_RESET = 32'd66;

    // one classified pair waiting for the back end
    typedef struct packed {
        logic signed [DIFF_W-1:0] dx;
        logic signed [DIFF_W-1:0] dy;
        logic [MASS_W-1:0]        mass;
        logic                     fresh;
        logic                     skip;
        logic                     last;
    } pair_t;

    // divider result
    typedef struct packed {
        logic              done;
        logic              sat;
        logic [TERM_W-1:0] mag;
    } div_res_t;

endpackage

// ===== rtl/nbpa_front.sv =====
// ----------------------------------------------------------------------------
// nbpa_front
// accepts pair transactions, forms the position differences and queues them
// ----------------------------------------------------------------------------
module nbpa_front (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [nbpa_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic [nbpa_pkg::S_TUSER_W-1:0] s_tuser,
    input  logic                           s_tlast,
    output logic                           q_valid,
    output nbpa_pkg::pair_t                q_item,
    input  logic                           q_pop
);
    import nbpa_pkg::*;

    pair_t       slot_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;
    logic        push;
    pair_t       in_item;

    logic signed [DIFF_W-1:0] tx, ty, sx, sy;

    assign tx = DIFF_W'($signed(s_tdata[POS_WIDTH-1:0]));
    assign ty = DIFF_W'($signed(s_tdata[2*POS_WIDTH-1:POS_WIDTH]));
    assign sx = DIFF_W'($signed(s_tdata[3*POS_WIDTH-1:2*POS_WIDTH]));
    assign sy = DIFF_W'($signed(s_tdata[4*POS_WIDTH-1:3*POS_WIDTH]));

    always_comb begin
        in_item.dx    = tx - sx;
        in_item.dy    = ty - sy;
        in_item.mass  = s_tdata[4*POS_WIDTH+MASS_W-1:4*POS_WIDTH];
        in_item.fresh = s_tuser[0];
        in_item.skip  = s_tuser[1];
        in_item.last  = s_tlast;
    end

    assign s_tready = (count_reg != 2'd2);
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (count_reg != 2'd0);
    assign q_item   = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(q_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

// ===== rtl/nbpa_sqrt.sv =====
// ----------------------------------------------------------------------------
// nbpa_sqrt
// integer square root, two radicand bits per cycle
// ----------------------------------------------------------------------------
module nbpa_sqrt (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [nbpa_pkg::RAD_W-1:0]  radicand,
    output logic                        done,
    output logic [nbpa_pkg::ROOT_W-1:0] root
);
    import nbpa_pkg::*;

    logic                  busy_reg, done_reg;
    logic [ROOT_CNT_W-1:0] cnt_reg;
    logic [RAD_W-1:0]      rad_reg;
    logic [ROOT_W+1:0]     rem_reg, rem_next;
    logic [ROOT_W-1:0]     root_reg, root_next;
    logic [ROOT_W+1:0]     rem2, trial;

    always_comb begin
        rem2  = {rem_reg[ROOT_W-1:0], rad_reg[RAD_W-1 -: 2]};
        trial = {root_reg, 2'b01};
        if (rem2 >= trial) begin
            rem_next  = rem2 - trial;
            root_next = {root_reg[ROOT_W-2:0], 1'b1};
        end else begin
            rem_next  = rem2;
            root_next = {root_reg[ROOT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= ROOT_CNT_W'(ROOT_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == ROOT_CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (busy_reg) begin
            rad_reg  <= {rad_reg[RAD_W-3:0], 2'b00};
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

// ===== rtl/nbpa_div.sv =====
// ----------------------------------------------------------------------------
// nbpa_div
// restoring divider, one quotient bit per cycle, saturating to 47 bits
// ----------------------------------------------------------------------------
module nbpa_div (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [nbpa_pkg::NUM_W-1:0] num,
    input  logic [nbpa_pkg::DEN_W-1:0] den,
    output nbpa_pkg::div_res_t         res
);
    import nbpa_pkg::*;

    logic                 busy_reg, done_reg, sat_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [REM_W-1:0]     rem_reg;
    logic [DEN_W-1:0]     den_reg;
    logic [Q_W-1:0]       lo_reg, q_reg;
    logic [REM_W-1:0]     rem2, den_ext, hi_ext;
    logic                 den_zero, hi_over, early, qbit;

    assign den_zero = (den == '0);
    assign hi_ext   = REM_W'(num[NUM_W-1:Q_W]);
    // quotient past 48 bits saturates, flagged now and held through the run
    assign hi_over  = !den_zero && (hi_ext >= REM_W'(den));
    // zero denominator gives a zero term; only this exits early, so the
    // x and y dividers sharing one denominator always finish together
    assign early    = den_zero;

    assign den_ext = REM_W'(den_reg);
    assign rem2    = {rem_reg[REM_W-2:0], lo_reg[Q_W-1]};
    assign qbit    = (rem2 >= den_ext);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= !early;
                done_reg <= early;
                cnt_reg  <= DIV_CNT_W'(Q_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DIV_CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= hi_ext;
            den_reg <= den;
            lo_reg  <= num[Q_W-1:0];
            q_reg   <= '0;
            sat_reg <= hi_over;
        end else if (busy_reg) begin
            rem_reg <= qbit ? (rem2 - den_ext) : rem2;
            lo_reg  <= {lo_reg[Q_W-2:0], 1'b0};
            q_reg   <= {q_reg[Q_W-2:0], qbit};
        end
    end

    always_comb begin
        res.done = done_reg;
        res.sat  = sat_reg || q_reg[Q_W-1];
        res.mag  = res.sat ? {TERM_W{1'b1}} : q_reg[TERM_W-1:0];
    end

endmodule

// ===== rtl/nbpa_back.sv =====
// ----------------------------------------------------------------------------
// nbpa_back
// per-pair sequencer: distance, cube, numerators, division, accumulation
// ----------------------------------------------------------------------------
module nbpa_back (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [nbpa_pkg::REG_IDX_W-1:0] cfg_addr,
    input  logic [nbpa_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic                           q_valid,
    input  nbpa_pkg::pair_t                q_item,
    output logic                           q_pop,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [nbpa_pkg::M_TDATA_W-1:0] m_tdata,
    output logic [nbpa_pkg::M_TUSER_W-1:0] m_tuser
);
    import nbpa_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SQX   = 4'd1;
    localparam logic [3:0] S_SQY   = 4'd2;
    localparam logic [3:0] S_RSTRT = 4'd3;
    localparam logic [3:0] S_ROOT  = 4'd4;
    localparam logic [3:0] S_D2    = 4'd5;
    localparam logic [3:0] S_D3L   = 4'd6;
    localparam logic [3:0] S_D3H   = 4'd7;
    localparam logic [3:0] S_GM    = 4'd8;
    localparam logic [3:0] S_NUML  = 4'd9;
    localparam logic [3:0] S_NUMH  = 4'd10;
    localparam logic [3:0] S_DSTRT = 4'd11;
    localparam logic [3:0] S_DIV   = 4'd12;
    localparam logic [3:0] S_ACC   = 4'd13;
    localparam logic [3:0] S_FIN   = 4'd14;

    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    logic [3:0]       state_reg, state_next;
    logic [CFG_W-1:0] grav_reg, soft_reg;

    pair_t            item_reg;
    logic [MAG_W-1:0] ux_reg, uy_reg;
    logic [RAD_W-1:0] s2_reg;
    logic [ROOT_W-1:0] d_reg;
    logic [D2_W-1:0]  d2_reg;
    logic [D3_W-1:0]  d3_reg;
    logic [DEN_W-1:0] den_reg;
    logic [GM_W-1:0]  gm_reg;
    logic [NX_W-1:0]  nx_reg, ny_reg;

    logic signed [ACC_W-1:0] sum_x_reg, sum_y_reg;
    logic                    clip_reg;
    logic                    out_valid_reg;
    logic [M_TDATA_W-1:0]    out_data_reg;
    logic                    out_clip_reg;
    logic                    out_load;

    logic              sq_start, sq_done;
    logic [ROOT_W-1:0] sq_root;
    logic              dv_start;
    div_res_t          dvx_res, dvy_res;
    logic [NUM_W-1:0]  num_x, num_y;

    logic signed [ACC_W-1:0] acc_x_val, acc_y_val;
    logic                    acc_x_clip, acc_y_clip;

    // saturating accumulate, sign of the difference picks the direction
    function automatic logic [ACC_W:0] acc_sub(input logic signed [ACC_W-1:0] sum,
                                               input logic neg,
                                               input logic [TERM_W-1:0] mag);
        logic signed [ACC_W:0] r;
        logic signed [ACC_W:0] m;
        m = {2'b00, mag};
        r = neg ? ({sum[ACC_W-1], sum} + m) : ({sum[ACC_W-1], sum} - m);
        if (r[ACC_W] != r[ACC_W-1]) begin
            acc_sub = {1'b1, (r[ACC_W] ? ACC_MIN : ACC_MAX)};
        end else begin
            acc_sub = {1'b0, r[ACC_W-1:0]};
        end
    endfunction

    always_comb begin
        {acc_x_clip, acc_x_val} = acc_sub(sum_x_reg, item_reg.dx[DIFF_W-1], dvx_res.mag);
        {acc_y_clip, acc_y_val} = acc_sub(sum_y_reg, item_reg.dy[DIFF_W-1], dvy_res.mag);
    end

    assign sq_start = (state_reg == S_RSTRT);
    assign dv_start = (state_reg == S_DSTRT);
    assign num_x    = {nx_reg, {FRAC_SHIFT{1'b0}}};
    assign num_y    = {ny_reg, {FRAC_SHIFT{1'b0}}};
    assign q_pop    = (state_reg == S_IDLE) && q_valid;
    assign out_load = (state_reg == S_FIN) && item_reg.last &&
                      (!out_valid_reg || m_tready);

    nbpa_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sq_start),
        .radicand (s2_reg),
        .done     (sq_done),
        .root     (sq_root)
    );

    nbpa_div u_div_x (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (dv_start),
        .num     (num_x),
        .den     (den_reg),
        .res     (dvx_res)
    );

    nbpa_div u_div_y (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (dv_start),
        .num     (num_y),
        .den     (den_reg),
        .res     (dvy_res)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (q_valid) begin
                         state_next = q_item.skip ? S_FIN : S_SQX;
                     end
            S_SQX:   state_next = S_SQY;
            S_SQY:   state_next = S_RSTRT;
            S_RSTRT: state_next = S_ROOT;
            S_ROOT:  if (sq_done) begin
                         state_next = S_D2;
                     end
            S_D2:    state_next = S_D3L;
            S_D3L:   state_next = S_D3H;
            S_D3H:   state_next = S_GM;
            S_GM:    state_next = S_NUML;
            S_NUML:  state_next = S_NUMH;
            S_NUMH:  state_next = S_DSTRT;
            S_DSTRT: state_next = S_DIV;
            S_DIV:   if (dvx_res.done) begin
                         state_next = S_ACC;
                     end
            S_ACC:   state_next = S_FIN;
            S_FIN:   if (!item_reg.last || out_load) begin
                         state_next = S_IDLE;
                     end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            grav_reg      <= GRAV_RESET;
            soft_reg      <= SOFT_RESET;
            sum_x_reg     <= '0;
            sum_y_reg     <= '0;
            clip_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    REG_GRAV_CONST: grav_reg <= cfg_wdata;
                    REG_SOFTENING:  soft_reg <= cfg_wdata;
                    default:        ;
                endcase
            end
            if (q_pop && q_item.fresh) begin
                sum_x_reg <= '0;
                sum_y_reg <= '0;
                clip_reg  <= 1'b0;
            end else if (state_reg == S_ACC) begin
                sum_x_reg <= acc_x_val;
                sum_y_reg <= acc_y_val;
                clip_reg  <= clip_reg | dvx_res.sat | dvy_res.sat | acc_x_clip | acc_y_clip;
            end
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            item_reg <= q_item;
            ux_reg   <= MAG_W'(q_item.dx[DIFF_W-1] ? -q_item.dx : q_item.dx);
            uy_reg   <= MAG_W'(q_item.dy[DIFF_W-1] ? -q_item.dy : q_item.dy);
        end
        unique case (state_reg)
            S_SQX:   s2_reg <= RAD_W'(ux_reg) * RAD_W'(ux_reg);
            S_SQY:   s2_reg <= s2_reg + RAD_W'(uy_reg) * RAD_W'(uy_reg);
            S_ROOT:  d_reg  <= sq_root;
            S_D2:    d2_reg <= D2_W'(d_reg) * D2_W'(d_reg);
            S_D3L:   d3_reg <= D3_W'(D2_W'(d2_reg[ROOT_W-1:0]) * D2_W'(d_reg));
            S_D3H:   d3_reg <= d3_reg + (D3_W'(D2_W'(d2_reg[D2_W-1:ROOT_W]) * D2_W'(d_reg))
                               << ROOT_W);
            S_GM: begin
                gm_reg  <= GM_W'(grav_reg) * GM_W'(item_reg.mass);
                den_reg <= DEN_W'(d3_reg) + DEN_W'({soft_reg, {SOFT_SHIFT{1'b0}}});
            end
            S_NUML: begin
                nx_reg <= NX_W'(gm_reg[GM_HALF-1:0]) * NX_W'(ux_reg);
                ny_reg <= NX_W'(gm_reg[GM_HALF-1:0]) * NX_W'(uy_reg);
            end
            S_NUMH: begin
                nx_reg <= nx_reg + ((NX_W'(gm_reg[GM_W-1:GM_HALF]) * NX_W'(ux_reg)) << GM_HALF);
                ny_reg <= ny_reg + ((NX_W'(gm_reg[GM_W-1:GM_HALF]) * NX_W'(uy_reg)) << GM_HALF);
            end
            default: ;
        endcase
        if (out_load) begin
            out_data_reg <= {sum_y_reg, sum_x_reg};
            out_clip_reg <= clip_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_clip_reg;

    a_sqrt_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        sq_done |-> (state_reg == S_ROOT))
        else $error("square root finished outside its wait state");

    a_div_lockstep: assert property (@(posedge aclk) disable iff (!aresetn)
        dvx_res.done == dvy_res.done)
        else $error("x and y dividers out of step");

    a_pop_needs_item: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_valid)
        else $error("queue popped while empty");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_tready) |=> ($stable(out_data_reg) && $stable(out_clip_reg)))
        else $error("pending result overwritten");

endmodule

// ===== rtl/nbody_pair_accel_accumulator.sv =====
// ----------------------------------------------------------------------------
// nbody_pair_accel_accumulator
// streaming accumulator of softened 2d gravitational acceleration
// ----------------------------------------------------------------------------
// Each input transaction carries one target/source pair in Q16.16 plus three
// flags: tuser[0] clears the running sums before the pair, tuser[1] marks a
// self pair that contributes nothing, and tlast emits the sums after the pair.
// The term G*m*dx/(d^3+softening) is computed exactly and subtracted from the
// Q24.24 sums; terms and sums saturate and set the clip flag sent in m_tuser.
// Once a pair leaves the queue, the square root unit forms one root bit per
// cycle over POS_WIDTH + 1 bits, then the two dividers, which run side by
// side, form one quotient bit per cycle over 48 bits, with sequencing and
// handoff states around them. A zero denominator (coincident bodies with
// zero softening) skips the division, and a skipped pair goes from idle
// straight to the final state. A two-entry queue holds pairs that arrive
// while the back end is busy, and the result register lets the next pair
// start while a result waits to be taken; a last pair stalls in its final
// cycle only while that register is still full and not being taken.
module nbody_pair_accel_accumulator (
    input  logic                           aclk,
    input  logic                           aresetn,
    // configuration writes
    input  logic                           cfg_wr_en,
    input  logic [nbpa_pkg::REG_IDX_W-1:0] cfg_addr,
    input  logic [nbpa_pkg::CFG_W-1:0]     cfg_wdata,
    // pair input
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // target_x, target_y, source_x, source_y, source_mass
    input  logic [nbpa_pkg::S_TDATA_W-1:0] s_tdata,
    // start_fresh, skip_pair
    input  logic [nbpa_pkg::S_TUSER_W-1:0] s_tuser,
    // last_source
    input  logic                           s_tlast,
    // result output
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // accel_x, accel_y
    output logic [nbpa_pkg::M_TDATA_W-1:0] m_tdata,
    // clipped
    output logic [nbpa_pkg::M_TUSER_W-1:0] m_tuser
);
    import nbpa_pkg::*;

    // queue between the classifying front and the arithmetic back
    logic  q_valid;
    logic  q_pop;
    pair_t q_item;

    nbpa_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    // sequencer, register file, accumulators and result register
    nbpa_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

// ===== dv/nbpa_checker.sv =====
// ----------------------------------------------------------------------------
// nbpa_checker
// watches the pair and result channels, predicts the accumulated
// acceleration and compares every result transaction field by field
// ----------------------------------------------------------------------------
module nbpa_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [nbpa_pkg::REG_IDX_W-1:0] cfg_addr,
    input  logic [nbpa_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [nbpa_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic [nbpa_pkg::S_TUSER_W-1:0] s_tuser,
    input  logic                           s_tlast,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [nbpa_pkg::M_TDATA_W-1:0] m_tdata,
    input  logic [nbpa_pkg::M_TUSER_W-1:0] m_tuser,
    output int                             err_cnt,
    output int                             accel_pending,
    output int                             accel_seen
);
    import nbpa_pkg::*;

    localparam longint ACC_MAX = 64'sh7FFF_FFFF_FFFF;
    localparam longint ACC_MIN = -ACC_MAX - 1;

    typedef struct {
        logic [47:0] ax;
        logic [47:0] ay;
        logic        clip;
    } accel_t;

    accel_t      accel_q[$];
    logic [31:0] grav_q, soft_q;
    longint      acc_x, acc_y;
    logic        clip_flag;

    function automatic logic [63:0] root_floor(input logic [255:0] v);
        logic [63:0]  r;
        logic [63:0]  c;
        logic [255:0] sq;
        r = 0;
        for (int b = POS_WIDTH; b >= 0; b--) begin
            c = r | (64'd1 << b);
            sq = 256'(c) * 256'(c);
            if (sq <= v) r = c;
        end
        return r;
    endfunction

    // floor(base*u/den), saturated to the 47 bit term range
    function automatic longint term_mag(input logic [255:0] base, input logic [63:0] u,
                                        input logic [255:0] den, inout logic clip);
        logic [255:0] q;
        if (den == 0) return 0;
        q = (base * 256'(u)) / den;
        if (q > 256'(ACC_MAX)) begin
            clip = 1'b1;
            return ACC_MAX;
        end
        return longint'(q[63:0]);
    endfunction

    function automatic longint acc_step(input longint s, input longint diff,
                                       input longint mag, inout logic clip);
        longint r;
        r = (diff < 0) ? s + mag : s - mag;
        if (r > ACC_MAX) begin
            clip = 1'b1;
            return ACC_MAX;
        end
        if (r < ACC_MIN) begin
            clip = 1'b1;
            return ACC_MIN;
        end
        return r;
    endfunction

    task automatic apply_pair();
        longint       dx, dy, mx, my;
        logic [63:0]  ux, uy, d;
        logic [255:0] den, base;
        accel_t       e;
        if (s_tuser[0]) begin
            acc_x = 0;
            acc_y = 0;
            clip_flag = 1'b0;
        end
        if (!s_tuser[1]) begin
            dx = longint'($signed(s_tdata[31:0])) - longint'($signed(s_tdata[95:64]));
            dy = longint'($signed(s_tdata[63:32])) - longint'($signed(s_tdata[127:96]));
            ux = (dx < 0) ? 64'(-dx) : 64'(dx);
            uy = (dy < 0) ? 64'(-dy) : 64'(dy);
            d = root_floor(256'(ux) * 256'(ux) + 256'(uy) * 256'(uy));
            den = 256'(d) * 256'(d) * 256'(d) + (256'(soft_q) << 32);
            base = (256'(grav_q) * 256'(s_tdata[159:128])) << 24;
            mx = term_mag(base, ux, den, clip_flag);
            my = term_mag(base, uy, den, clip_flag);
            acc_x = acc_step(acc_x, dx, mx, clip_flag);
            acc_y = acc_step(acc_y, dy, my, clip_flag);
        end
        if (s_tlast) begin
            e.ax = acc_x[47:0];
            e.ay = acc_y[47:0];
            e.clip = clip_flag;
            accel_q.push_back(e);
        end
    endtask

    always @(posedge aclk) begin
        accel_t e;
        if (!aresetn) begin
            grav_q = GRAV_RESET;
            soft_q = SOFT_RESET;
            acc_x = 0;
            acc_y = 0;
            clip_flag = 1'b0;
            accel_q.delete();
            err_cnt <= 0;
            accel_seen <= 0;
        end else begin
            if (cfg_wr_en) begin
                if (cfg_addr == REG_GRAV_CONST) grav_q = cfg_wdata;
                else if (cfg_addr == REG_SOFTENING) soft_q = cfg_wdata;
            end
            if (s_tvalid && s_tready) apply_pair();
            if (m_tvalid && m_tready) begin
                accel_seen <= accel_seen + 1;
                if (accel_q.size() == 0) begin
                    $display("%0t: unexpected result ax=%h ay=%h clip=%b", $time,
                             m_tdata[47:0], m_tdata[95:48], m_tuser[0]);
                    err_cnt <= err_cnt + 1;
                end else begin
                    e = accel_q.pop_front();
                    if (m_tdata[47:0] !== e.ax || m_tdata[95:48] !== e.ay
                        || m_tuser[0] !== e.clip) begin
                        $display("%0t: mismatch expected ax=%h ay=%h clip=%b, got ax=%h ay=%h clip=%b",
                                 $time, e.ax, e.ay, e.clip,
                                 m_tdata[47:0], m_tdata[95:48], m_tuser[0]);
                        err_cnt <= err_cnt + 1;
                    end
                end
            end
        end
        accel_pending <= accel_q.size();
    end

endmodule

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// drives pair transactions and configuration phases into the accumulator,
// with random idling on both sides and one long result back-pressure
// stretch; the checker predicts and compares every result
// ----------------------------------------------------------------------------
module tb_top;
    import nbpa_pkg::*;

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_wr_en;
    logic [REG_IDX_W-1:0] cfg_addr;
    logic [CFG_W-1:0]     cfg_wdata;
    logic                 s_tvalid;
    logic                 s_tready;
    // target_x, target_y, source_x, source_y, source_mass
    logic [S_TDATA_W-1:0] s_tdata;
    // start_fresh, skip_pair
    logic [S_TUSER_W-1:0] s_tuser;
    logic                 s_tlast;
    logic                 m_tvalid;
    logic                 m_tready;
    // accel_x, accel_y
    logic [M_TDATA_W-1:0] m_tdata;
    // clipped
    logic [M_TUSER_W-1:0] m_tuser;

    int   err_cnt, accel_pending, accel_seen;
    int   pairs_sent;
    logic quiet;      // last part of the run: no idling
    logic hold_req;   // asks the result side for one long stall

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    nbody_pair_accel_accumulator uut (.*);

    nbpa_checker chk (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .err_cnt(err_cnt), .accel_pending(accel_pending), .accel_seen(accel_seen)
    );

    // generous fixed limit, far above the slowest correct run
    initial begin
        #20000000;
        $display("timeout waiting for results");
        $display("CHECKS FAILED");
        $finish;
    end

    // result side: random stall bursts, plus one long stall on request
    initial begin
        int stall_cycles;
        m_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                // long hold-off counted here while pairs keep coming
                m_tready = 1'b0;
                stall_cycles = 0;
                while (stall_cycles < 1500) begin
                    @(negedge aclk);
                    stall_cycles++;
                end
                hold_req = 1'b0;
                m_tready = 1'b1;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                m_tready = 1'b0;
                repeat ($urandom_range(1, 18)) @(negedge aclk);
                m_tready = 1'b1;
            end else begin
                m_tready = 1'b1;
            end
        end
    end

    // one pair transaction, with an optional idle burst in front
    task automatic send_pair(input logic [31:0] tx, input logic [31:0] ty,
                             input logic [31:0] sx, input logic [31:0] sy,
                             input logic [31:0] mass, input logic fresh,
                             input logic skip, input logic last);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata = {mass, sy, sx, ty, tx};
        s_tuser = {skip, fresh};
        s_tlast = last;
        do @(posedge aclk); while (!s_tready);
        pairs_sent++;
        @(negedge aclk);
    endtask

    // registers change only once the block has drained
    task automatic write_regs(input logic [31:0] grav, input logic [31:0] soft_val);
        s_tvalid = 1'b0;
        while (accel_pending != 0) @(negedge aclk);
        // a trailing pair without tlast may still be in flight
        repeat (300) @(negedge aclk);
        cfg_wr_en = 1'b1;
        cfg_addr = REG_GRAV_CONST;
        cfg_wdata = grav;
        @(negedge aclk);
        cfg_addr = REG_SOFTENING;
        cfg_wdata = soft_val;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    function automatic logic [31:0] rand_pos(input logic [31:0] near);
        case ($urandom_range(0, 3))
            0: return $urandom();
            1: return near + $signed($urandom_range(0, 32'h3_0000)) - 32'sh1_8000;
            default: return near + $signed($urandom_range(0, 32'h60_0000)) - 32'sh30_0000;
        endcase
    endfunction

    function automatic logic [31:0] rand_mass();
        case ($urandom_range(0, 3))
            0: return $urandom();
            1: return 32'hFFFF_FFFF;
            default: return $urandom_range(0, 32'h10_0000);
        endcase
    endfunction

    // one target against a run of sources; mostly well formed, some noise
    task automatic send_target();
        logic [31:0] tx, ty;
        int          n;
        tx = (($urandom_range(0, 3) == 0) ? $urandom() : ($urandom() & 32'h00FF_FFFF));
        ty = (($urandom_range(0, 3) == 0) ? $urandom() : ($urandom() & 32'h00FF_FFFF));
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 9) == 0)
                send_pair($urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)));
            else if ($urandom_range(0, 7) == 0)
                // self pair
                send_pair(tx, ty, tx, ty, rand_mass(), i == 0, 1'b1, i == n - 1);
            else
                send_pair(tx, ty, rand_pos(tx), rand_pos(ty), rand_mass(),
                          i == 0, 1'b0, i == n - 1);
        end
    endtask

    initial begin
        quiet = 1'b0;
        hold_req = 1'b0;
        pairs_sent = 0;
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_addr = REG_GRAV_CONST;
        cfg_wdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        s_tlast = 1'b0;
        repeat (3) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // directed part at reset settings
        send_pair(32'h0001_0000, 0, 0, 0, 32'h0001_0000, 1, 0, 1);
        send_pair(0, 32'h0001_0000, 0, 0, 32'h0001_0000, 1, 0, 1);
        send_pair(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                  32'hFFFF_FFFF, 1, 0, 1);
        // coincident bodies, then a skipped self pair
        send_pair(32'h1234_5678, 32'h1234_5678, 32'h1234_5678, 32'h1234_5678,
                  32'hFFFF_FFFF, 1, 0, 0);
        send_pair(5, 7, 5, 7, 32'hFFFF_FFFF, 0, 1, 1);
        // close, heavy sources build up the sums over four emitted pairs
        for (int i = 0; i < 4; i++)
            send_pair(2, 0, 0, 0, 32'hFFFF_FFFF, i == 0, 0, 1);
        // sums survive emission, then a fresh start clears them
        send_pair(0, 0, 32'h0000_8000, 32'hFFFF_8000, 32'h0010_0000, 0, 0, 1);
        send_pair(0, 0, 32'h0000_8000, 32'hFFFF_8000, 32'h0010_0000, 1, 0, 1);
        // fresh start on a skipped pair
        send_pair(1, 1, 1, 1, 0, 1, 1, 1);

        // extreme register settings, zero softening with coincident bodies
        write_regs(32'hFFFF_FFFF, 0);
        send_pair(0, 0, 0, 0, 32'hFFFF_FFFF, 1, 0, 1);
        send_pair(32'h7FFF_FFFF, 0, 32'h8000_0000, 0, 32'hFFFF_FFFF, 1, 0, 1);
        send_pair(32'h0100_0000, 32'h0100_0000, 0, 0, 1, 1, 0, 1);
        write_regs(0, 32'hFFFF_FFFF);
        send_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 32'hFFFF_FFFF, 1, 0, 1);
        send_pair(3, 0, 0, 3, 32'hFFFF_FFFF, 1, 0, 1);

        // random part over several settings; the long stall falls in the first
        write_regs(32'h0001_0000, 32'd66);
        hold_req = 1'b1;
        while (pairs_sent < 220) send_target();
        write_regs(32'hFFFF_FFFF, 0);
        while (pairs_sent < 380) send_target();
        write_regs($urandom(), $urandom_range(0, 32'h0001_0000));
        while (pairs_sent < 540) send_target();
        write_regs(0, $urandom());
        while (pairs_sent < 600) send_target();
        write_regs($urandom_range(1, 32'h0010_0000), $urandom());
        while (pairs_sent < 700) send_target();
        quiet = 1'b1;
        while (pairs_sent < 820) send_target();
        s_tvalid = 1'b0;

        while (accel_pending != 0) @(negedge aclk);
        repeat (300) @(negedge aclk);

        $display("sent %0d pair transactions over six register settings, %0d results checked",
                 pairs_sent, accel_seen);
        $display("covered saturation, coincident and self pairs, zero softening, long stall");
        if (err_cnt == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ===== nbody_pair_accel_accumulator.f =====
rtl/nbpa_pkg.sv
rtl/nbpa_front.sv
rtl/nbpa_sqrt.sv
rtl/nbpa_div.sv
rtl/nbpa_back.sv
rtl/nbody_pair_accel_accumulator.sv
dv/nbpa_checker.sv
dv/tb_top.sv
